@@ rtl/core/dns_a_record_data_framer_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the A-record data framer
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DNS_A_RECORD_DATA_FRAMER_TOP_MACROS_SVH
`define DNS_A_RECORD_DATA_FRAMER_TOP_MACROS_SVH

// Implication checked in the same cycle.
`define DRF_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent.
`define DRF_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/drf_pkg.sv @@
// ----------------------------------------------------------------------------
// A-record data framer package
// Sizes, codes, shared types and pointer arithmetic for the framer.
// ----------------------------------------------------------------------------
package drf_pkg;

   localparam int BUFFER_DEPTH = 256;
   localparam int PTR_W = $clog2(BUFFER_DEPTH);
   localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
   localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

   localparam int QUEUE_DEPTH = 2;
   localparam int Q_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] OP_PUSH_BYTE   = 2'd0;
   localparam logic [1:0] OP_PULL_RECORD = 2'd1;
   localparam logic [1:0] OP_PUSH_RECORD = 2'd2;

   localparam logic REG_DIRECTION = 1'b0;
   localparam logic REG_LIMIT     = 1'b1;

   localparam logic DIR_OUT = 1'b0;
   localparam logic DIR_IN  = 1'b1;

   localparam logic KIND_RECORD  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   typedef logic [PTR_W-1:0] ptr_type;

   typedef struct packed {
      logic            is_rec;
      logic [3:0][7:0] byts;
      logic [1:0]      first;
      logic [1:0]      count;
      ptr_type         addr;
   } entry_type;

   typedef struct packed {
      logic       we;
      ptr_type    addr;
      logic [7:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic rd_issue;
   } bk_status_type;

   typedef enum logic {
      BK_RUN,
      BK_FIN
   } bk_state_type;

   function automatic ptr_type ptr_add(ptr_type p, logic [1:0] k);
      logic [CNT_W-1:0] s;
      s = CNT_W'(p) + CNT_W'(k);
      if (s >= CNT_W'(BUFFER_DEPTH)) begin
         s = s - CNT_W'(BUFFER_DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

endpackage

@@ rtl/core/drf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module drf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/drf_front.sv @@
// ----------------------------------------------------------------------------
// Framer front end
// Accepts items, keeps the FIFO bookkeeping and sequence state, writes pushed
// bytes into the byte store and queues record and payload jobs.
// ----------------------------------------------------------------------------
module drf_front
   import drf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic          csr_index,
   input  logic [6:0]    csr_data,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_operation,
   input  logic [7:0]    req_in_b0,
   input  logic [7:0]    req_in_b1,
   input  logic [7:0]    req_in_b2,
   input  logic [7:0]    req_in_b3,
   input  logic          q_full,
   output logic          q_push,
   output entry_type     q_entry,
   output ram_wr_type    ram_wr,
   input  bk_status_type bk_status
);

   logic             dir_ff, dir_in;
   logic [6:0]       limit_ff, limit_in;
   logic [6:0]       seq_ff, seq_in;
   logic [7:0]       rem_ff, rem_in;
   ptr_type          rd_ptr_ff, rd_ptr_in;
   ptr_type          wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] pend_ff, pend_in;

   logic             fire;
   logic             seq_zero;
   logic [6:0]       eff_limit;
   logic [6:0]       seq_inc;
   logic [6:0]       seq_adv;
   logic [8:0]       three_lim;
   logic [CMP_W-1:0] fill_ext;
   logic [CMP_W-1:0] lim_ext;
   logic [CMP_W-1:0] len_min;
   logic [7:0]       len;
   logic [1:0]       pull_cap;
   logic [1:0]       pull_n;
   logic             rec_match;
   logic             rec_first;
   logic [7:0]       rec_base;
   logic [1:0]       rec_cap;
   logic [1:0]       rec_n;
   logic [7:0]       rec_rem;
   logic             has_room;
   logic [CNT_W:0]   occupied;
   logic [1:0]       pend_add;

   assign csr_ready = 1'b1;

   assign occupied  = {1'b0, fill_ff} + {1'b0, pend_ff};
   assign has_room  = fill_ff < CNT_W'(BUFFER_DEPTH);
   assign req_ready = !q_full && (!has_room || occupied < (CNT_W + 1)'(BUFFER_DEPTH));
   assign fire      = req_valid && req_ready;

   assign seq_zero  = seq_ff == 7'd0;
   assign eff_limit = (limit_ff == 7'd0) ? 7'd1 : limit_ff;
   assign seq_inc   = seq_ff + 7'd1;
   assign seq_adv   = (seq_inc >= eff_limit) ? 7'd0 : seq_inc;

   assign three_lim = ({2'b00, eff_limit} << 1) + {2'b00, eff_limit} - 9'd1;
   assign fill_ext  = CMP_W'(fill_ff);
   assign lim_ext   = CMP_W'(three_lim);
   assign len_min   = (lim_ext < fill_ext) ? lim_ext : fill_ext;
   assign len       = (len_min > CMP_W'(255)) ? 8'd255 : len_min[7:0];
   assign pull_cap  = seq_zero ? 2'd2 : 2'd3;
   assign pull_n    = (fill_ff < CNT_W'(pull_cap)) ? fill_ff[1:0] : pull_cap;

   assign rec_match = req_in_b0 == {1'b0, seq_ff};
   assign rec_first = req_in_b0 == 8'd0;
   assign rec_base  = rec_first ? req_in_b1 : rem_ff;
   assign rec_cap   = rec_first ? 2'd2 : 2'd3;
   assign rec_n     = (rec_base < {6'd0, rec_cap}) ? rec_base[1:0] : rec_cap;
   assign rec_rem   = rec_base - {6'd0, rec_n};

   always_comb begin
      dir_in    = dir_ff;
      limit_in  = limit_ff;
      seq_in    = seq_ff;
      rem_in    = rem_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      fill_in   = fill_ff;
      pend_add  = 2'd0;
      q_push    = 1'b0;
      q_entry   = '0;
      ram_wr    = '0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DIRECTION: dir_in = csr_data[0];
            REG_LIMIT:     limit_in = csr_data;
            default:       dir_in = dir_ff;
         endcase
      end

      if (fire && dir_ff == DIR_OUT && req_operation == OP_PUSH_BYTE) begin
         if (has_room) begin
            ram_wr.we   = 1'b1;
            ram_wr.addr = wr_ptr_ff;
            ram_wr.data = req_in_b0;
            wr_ptr_in   = ptr_add(wr_ptr_ff, 2'd1);
            fill_in     = fill_ff + CNT_W'(1);
         end
         seq_in = 7'd0;
      end

      if (fire && dir_ff == DIR_OUT && req_operation == OP_PULL_RECORD && fill_ff != '0) begin
         q_push          = 1'b1;
         q_entry.is_rec  = 1'b1;
         q_entry.byts[0] = {1'b0, seq_ff};
         q_entry.byts[1] = seq_zero ? len : 8'd0;
         q_entry.first   = seq_zero ? 2'd2 : 2'd1;
         q_entry.count   = pull_n;
         q_entry.addr    = rd_ptr_ff;
         rd_ptr_in       = ptr_add(rd_ptr_ff, pull_n);
         fill_in         = fill_ff - CNT_W'(pull_n);
         pend_add        = pull_n;
         seq_in          = seq_adv;
      end

      if (fire && dir_ff == DIR_IN && req_operation == OP_PUSH_RECORD && rec_match) begin
         q_push          = rec_n != 2'd0;
         q_entry.is_rec  = 1'b0;
         q_entry.byts[0] = req_in_b0;
         q_entry.byts[1] = req_in_b1;
         q_entry.byts[2] = req_in_b2;
         q_entry.byts[3] = req_in_b3;
         q_entry.first   = rec_first ? 2'd2 : 2'd1;
         q_entry.count   = rec_n;
         rem_in          = rec_rem;
         seq_in          = (rec_rem == 8'd0) ? 7'd0 : seq_adv;
      end

      pend_in = pend_ff + CNT_W'(pend_add) - CNT_W'(bk_status.rd_issue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff    <= DIR_OUT;
         limit_ff  <= 7'd1;
         seq_ff    <= 7'd0;
         rem_ff    <= 8'd0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
         pend_ff   <= '0;
      end else begin
         dir_ff    <= dir_in;
         limit_ff  <= limit_in;
         seq_ff    <= seq_in;
         rem_ff    <= rem_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
         pend_ff   <= pend_in;
      end
   end

endmodule

@@ rtl/core/drf_queue.sv @@
// ----------------------------------------------------------------------------
// Framer job queue
// A short register FIFO of jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module drf_queue
   import drf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head
);

   entry_type          slots [QUEUE_DEPTH];
   logic [Q_IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [Q_IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = count_ff == Q_CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = slots[rd_idx_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_idx_in = (wr_idx_ff == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_ff + Q_IDX_W'(1);
      end
      if (do_pop) begin
         rd_idx_in = (rd_idx_ff == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_ff + Q_IDX_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_idx_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/core/drf_back.sv @@
// ----------------------------------------------------------------------------
// Framer back end
// Reads record bytes from the byte store one per cycle, assembles records,
// splits incoming records into payload bytes and drives the result register.
// ----------------------------------------------------------------------------
`include "dns_a_record_data_framer_top_macros.svh"

module drf_back
   import drf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  entry_type     q_head,
   output logic          q_pop,
   output ptr_type       rd_addr,
   input  logic [7:0]    rd_data,
   output bk_status_type bk_status,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_out_kind,
   output logic [7:0]    rsp_out_b0,
   output logic [7:0]    rsp_out_b1,
   output logic [7:0]    rsp_out_b2,
   output logic [7:0]    rsp_out_b3,
   output logic          rsp_last
);

   bk_state_type    state_ff, state_in;
   logic [1:0]      idx_ff, idx_in;
   logic            cap_valid_ff, cap_valid_in;
   logic [1:0]      cap_pos_ff, cap_pos_in;
   logic [3:0][7:0] asm_ff, asm_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            kind_ff, kind_in;
   logic [3:0][7:0] bytes_ff, bytes_in;
   logic            last_ff, last_in;
   logic            out_free;
   logic            is_last;
   logic [3:0][7:0] merged;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_last  = idx_ff == (q_head.count - 2'd1);

   always_comb begin
      merged = asm_ff;
      if (cap_valid_ff) begin
         merged[cap_pos_ff] = rd_data;
      end
   end

   always_comb begin
      state_in           = state_ff;
      idx_in             = idx_ff;
      cap_valid_in       = 1'b0;
      cap_pos_in         = cap_pos_ff;
      asm_in             = merged;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      kind_in            = kind_ff;
      bytes_in           = bytes_ff;
      last_in            = last_ff;
      q_pop              = 1'b0;
      rd_addr            = ptr_add(q_head.addr, idx_ff);
      bk_status.rd_issue = 1'b0;

      case (state_ff)
         BK_RUN: begin
            if (q_valid && q_head.is_rec) begin
               bk_status.rd_issue = 1'b1;
               cap_valid_in       = 1'b1;
               cap_pos_in         = q_head.first + idx_ff;
               if (idx_ff == 2'd0) begin
                  asm_in = q_head.byts;
               end
               if (is_last) begin
                  idx_in   = 2'd0;
                  state_in = BK_FIN;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end else if (q_valid && out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_PAYLOAD;
               bytes_in     = '0;
               bytes_in[0]  = q_head.byts[q_head.first + idx_ff];
               last_in      = is_last;
               if (is_last) begin
                  q_pop  = 1'b1;
                  idx_in = 2'd0;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         BK_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_RECORD;
               bytes_in     = merged;
               last_in      = 1'b1;
               q_pop        = 1'b1;
               state_in     = BK_RUN;
            end
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_RUN;
         idx_ff       <= 2'd0;
         cap_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cap_valid_ff <= cap_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_pos_ff <= cap_pos_in;
      asm_ff     <= asm_in;
      kind_ff    <= kind_in;
      bytes_ff   <= bytes_in;
      last_ff    <= last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_kind = kind_ff;
   assign rsp_out_b0   = bytes_ff[0];
   assign rsp_out_b1   = bytes_ff[1];
   assign rsp_out_b2   = bytes_ff[2];
   assign rsp_out_b3   = bytes_ff[3];
   assign rsp_last     = last_ff;

   `DRF_ASSERT_SAME(a_fin_has_record, state_ff == BK_FIN, q_valid && q_head.is_rec, "record job lost while assembling")
   `DRF_ASSERT_NEXT(a_read_captured, bk_status.rd_issue, cap_valid_ff, "byte store read not captured")
   `DRF_ASSERT_SAME(a_index_in_range, state_ff == BK_RUN && q_valid, idx_ff < q_head.count, "job index past its byte count")

endmodule

@@ rtl/core/dns_a_record_data_framer_top.sv @@
// ----------------------------------------------------------------------------
// A-record data framer, top level
// Packs a byte stream into runs of 4-byte address records, or unpacks such
// runs back into bytes, as set by the direction register.
//
//   Port group | Flow | What it carries
//   csr_*      | in   | register index and write data, always ready
//   req_*      | in   | operation code and four record or data bytes
//   rsp_*      | out  | result kind, four bytes, last flag
//
// Pushes and dropped items are handled in the front end alone.
// A record pull reads its n data bytes (up to 3) one at a time through the
// single read port of the byte store, then emits the record; a payload emits one result per byte.
// A two-entry job queue lets the front end keep accepting items meanwhile.
// Reset is synchronous and needs no clearing pass; the byte store is unset.
// A stalled result holds in the output register; the back end waits on it.
// ----------------------------------------------------------------------------
module dns_a_record_data_framer_top
   import drf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [6:0] csr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_in_b0,
   input  logic [7:0] req_in_b1,
   input  logic [7:0] req_in_b2,
   input  logic [7:0] req_in_b3,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_out_kind,
   output logic [7:0] rsp_out_b0,
   output logic [7:0] rsp_out_b1,
   output logic [7:0] rsp_out_b2,
   output logic [7:0] rsp_out_b3,
   output logic       rsp_last
);

   logic          q_full;
   logic          q_push;
   entry_type     q_entry;
   logic          q_pop;
   logic          q_valid;
   entry_type     q_head;
   ram_wr_type    ram_wr;
   ptr_type       rd_addr;
   logic [7:0]    rd_data;
   bk_status_type bk_status;

   drf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_in_b0     (req_in_b0),
      .req_in_b1     (req_in_b1),
      .req_in_b2     (req_in_b2),
      .req_in_b3     (req_in_b3),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_entry),
      .ram_wr        (ram_wr),
      .bk_status     (bk_status)
   );

   drf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head       (q_head)
   );

   drf_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr.we),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   drf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .bk_status    (bk_status),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_b0   (rsp_out_b0),
      .rsp_out_b1   (rsp_out_b1),
      .rsp_out_b2   (rsp_out_b2),
      .rsp_out_b3   (rsp_out_b3),
      .rsp_last     (rsp_last)
   );

endmodule

@@ tb/sv/dns_a_record_data_framer_checker.sv @@
// ----------------------------------------------------------------------------
// A-record data framer result checker
// Watches the register, request and result channels of the framer. It keeps
// its own copy of the byte buffer, the run sequence and the payload count,
// predicts the results of every accepted item and compares each accepted
// result with the oldest one still owed.
// ----------------------------------------------------------------------------
module dns_a_record_data_framer_checker
   import drf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic       csr_index,
   input  logic [6:0] csr_data,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_in_b0,
   input  logic [7:0] req_in_b1,
   input  logic [7:0] req_in_b2,
   input  logic [7:0] req_in_b3,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_out_kind,
   input  logic [7:0] rsp_out_b0,
   input  logic [7:0] rsp_out_b1,
   input  logic [7:0] rsp_out_b2,
   input  logic [7:0] rsp_out_b3,
   input  logic       rsp_last,
   output int         fail_count,
   output int         results_waiting,
   output int         results_checked
);

   typedef struct packed {
      logic       kind;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
      logic       last;
   } framer_result_type;

   framer_result_type owed_results[$];
   framer_result_type got_result;
   framer_result_type want_result;

   logic [7:0]       held_bytes [BUFFER_DEPTH];
   ptr_type          head_ptr;
   ptr_type          tail_ptr;
   logic [CNT_W-1:0] held_count;
   logic [6:0]       run_seq;
   logic [7:0]       payload_left;
   logic             dir_reg;
   logic [6:0]       limit_reg;

   function automatic logic [6:0] next_seq(input logic [6:0] seq, input int lim);
      logic [6:0] nxt;
      nxt = seq + 7'd1;
      if (int'(nxt) >= lim) begin
         nxt = '0;
      end
      return nxt;
   endfunction

   task automatic frame_item(input logic [1:0] op, input logic [7:0] b0, b1, b2, b3);
      logic [3:0][7:0]   rec;
      logic [3:0][7:0]   recv;
      int                lim;
      int                len;
      int                first;
      int                n;
      int                j;
      framer_result_type res;
      begin
         lim = (limit_reg == 7'd0) ? 1 : int'(limit_reg);
         rec = '0;
         recv = {b3, b2, b1, b0};
         if (dir_reg == DIR_OUT && op == OP_PUSH_BYTE) begin
            if (int'(held_count) < BUFFER_DEPTH) begin
               held_bytes[tail_ptr] = b0;
               tail_ptr = ptr_type'((int'(tail_ptr) + 1) % BUFFER_DEPTH);
               held_count = held_count + 1'b1;
            end
            run_seq = '0;
         end else if (dir_reg == DIR_OUT && op == OP_PULL_RECORD && held_count != 0) begin
            rec[0] = {1'b0, run_seq};
            if (run_seq == 7'd0) begin
               len = 3 * lim - 1;
               if (len > int'(held_count)) begin
                  len = int'(held_count);
               end
               if (len > 255) begin
                  len = 255;
               end
               rec[1] = 8'(len);
               first = 2;
            end else begin
               first = 1;
            end
            n = 4 - first;
            if (int'(held_count) < n) begin
               n = int'(held_count);
            end
            for (j = 0; j < n; j++) begin
               rec[first + j] = held_bytes[head_ptr];
               head_ptr = ptr_type'((int'(head_ptr) + 1) % BUFFER_DEPTH);
               held_count = held_count - 1'b1;
            end
            run_seq = next_seq(run_seq, lim);
            res = '{KIND_RECORD, rec[0], rec[1], rec[2], rec[3], 1'b1};
            owed_results.push_back(res);
         end else if (dir_reg == DIR_IN && op == OP_PUSH_RECORD && b0 == {1'b0, run_seq}) begin
            if (b0 == 8'd0) begin
               payload_left = b1;
               first = 2;
            end else begin
               first = 1;
            end
            n = 4 - first;
            if (int'(payload_left) < n) begin
               n = int'(payload_left);
            end
            payload_left = payload_left - 8'(n);
            for (j = 0; j < n; j++) begin
               res = '{KIND_PAYLOAD, recv[first + j], 8'd0, 8'd0, 8'd0, (j == n - 1)};
               owed_results.push_back(res);
            end
            run_seq = next_seq(run_seq, lim);
            if (payload_left == 8'd0) begin
               run_seq = '0;
            end
         end
      end
   endtask

   task automatic flag_result(input string what, input bit have_want,
                              input framer_result_type want, input framer_result_type got);
      begin
         fail_count++;
         if (fail_count <= 10) begin
            if (have_want) begin
               $display("%0t %s: expected kind=%0d bytes=%02h %02h %02h %02h last=%0d",
                        $realtime, what, want.kind, want.b0, want.b1, want.b2, want.b3,
                        want.last);
            end else begin
               $display("%0t %s: nothing expected", $realtime, what);
            end
            $display("%0t %s: actual   kind=%0d bytes=%02h %02h %02h %02h last=%0d",
                     $realtime, what, got.kind, got.b0, got.b1, got.b2, got.b3, got.last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         owed_results.delete();
         head_ptr = '0;
         tail_ptr = '0;
         held_count = '0;
         run_seq = '0;
         payload_left = '0;
         dir_reg = DIR_OUT;
         limit_reg = 7'd1;
         fail_count = 0;
         results_checked = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_result = '{rsp_out_kind, rsp_out_b0, rsp_out_b1, rsp_out_b2, rsp_out_b3,
                           rsp_last};
            if (owed_results.size() == 0) begin
               flag_result("unexpected result", 1'b0, '0, got_result);
            end else begin
               want_result = owed_results.pop_front();
               if (got_result !== want_result) begin
                  flag_result("result mismatch", 1'b1, want_result, got_result);
               end
               results_checked++;
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_DIRECTION) begin
               dir_reg = csr_data[0];
            end else begin
               limit_reg = csr_data;
            end
         end
         if (req_valid && req_ready) begin
            frame_item(req_operation, req_in_b0, req_in_b1, req_in_b2, req_in_b3);
         end
      end
      results_waiting = owed_results.size();
   end

endmodule

@@ tb/sv/dns_a_record_data_framer_top_tb.sv @@
// ----------------------------------------------------------------------------
// A-record data framer testbench
// Drives directed and random items into the framer in both directions and
// over several register settings, with bursty requests and a stalling result
// sink. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module dns_a_record_data_framer_top_tb;
   import drf_pkg::*;

   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam int         SETTLE = 32;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = REG_DIRECTION;
   logic [6:0] csr_data = '0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_operation = OP_PUSH_BYTE;
   logic [7:0] req_in_b0 = '0;
   logic [7:0] req_in_b1 = '0;
   logic [7:0] req_in_b2 = '0;
   logic [7:0] req_in_b3 = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_out_kind;
   logic [7:0] rsp_out_b0;
   logic [7:0] rsp_out_b1;
   logic [7:0] rsp_out_b2;
   logic [7:0] rsp_out_b3;
   logic       rsp_last;

   int fail_count;
   int results_waiting;
   int results_checked;

   int burst_left = 0;
   int items_sent = 0;
   int settings_used = 0;
   int sink_mode = 0;
   int sink_cycles = 0;

   dns_a_record_data_framer_top DUT (.*);

   dns_a_record_data_framer_checker framer_check (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("dns_a_record_data_framer_top_tb failed");
      $finish;
   end

   // The result sink switches between always ready, mostly ready and mostly
   // stalled for stretches of random length.
   always @(posedge clock) begin
      if (sink_cycles == 0) begin
         sink_mode <= $urandom_range(0, 2);
         sink_cycles <= $urandom_range(20, 80);
      end else begin
         sink_cycles <= sink_cycles - 1;
      end
      case (sink_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [7:0] b0, b1, b2, b3);
      int gap;
      bit took;
      begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 20);
         end
         burst_left--;
         req_valid <= 1'b1;
         req_operation <= op;
         req_in_b0 <= b0;
         req_in_b1 <= b1;
         req_in_b2 <= b2;
         req_in_b3 <= b3;
         took = 1'b0;
         while (!took) begin
            @(negedge clock);
            took = req_ready;
            @(posedge clock);
         end
         items_sent++;
      end
   endtask

   task automatic drain_block(input int settle);
      begin
         req_valid <= 1'b0;
         do @(negedge clock); while (results_waiting != 0);
         @(posedge clock);
         repeat (settle) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic idx, input logic [6:0] value);
      bit took;
      begin
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data <= value;
         took = 1'b0;
         while (!took) begin
            @(negedge clock);
            took = csr_ready;
            @(posedge clock);
         end
         csr_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic set_config(input logic dir, input int lim);
      begin
         drain_block(SETTLE);
         write_reg(REG_DIRECTION, {6'($urandom_range(0, 63)), dir});
         write_reg(REG_LIMIT, 7'(lim));
         settings_used++;
      end
   endtask

   task automatic send_run(input int cap, input bit cut_short);
      int len;
      int left;
      int seq_no;
      begin
         if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(0, cap);
         end else begin
            len = $urandom_range(0, (cap < 12) ? cap : 12);
         end
         send_item(OP_PUSH_RECORD, 8'd0, 8'(len), rand_byte(), rand_byte());
         left = (len < 2) ? 0 : len - 2;
         seq_no = 1;
         while (left > 0 && !cut_short) begin
            send_item(OP_PUSH_RECORD, 8'(seq_no), rand_byte(), rand_byte(), rand_byte());
            left = (left < 3) ? 0 : left - 3;
            seq_no++;
         end
      end
   endtask

   task automatic run_phase(input logic dir, input int lim, input int count);
      int target;
      int pick;
      int cap;
      logic [1:0] noise_op;
      begin
         set_config(dir, lim);
         cap = 3 * ((lim == 0) ? 1 : lim) - 1;
         if (cap > 255) begin
            cap = 255;
         end
         target = items_sent + count;
         while (items_sent < target) begin
            if ($urandom_range(0, 24) == 0) begin
               drain_block(0);
            end
            pick = $urandom_range(0, 9);
            if (dir == DIR_OUT) begin
               if (pick < 8) begin
                  repeat ($urandom_range(1, 6)) begin
                     send_item(OP_PUSH_BYTE, rand_byte(), rand_byte(), rand_byte(),
                               rand_byte());
                  end
                  repeat ($urandom_range(1, 3)) begin
                     send_item(OP_PULL_RECORD, rand_byte(), rand_byte(), rand_byte(),
                               rand_byte());
                  end
               end else begin
                  noise_op = (pick == 8) ? OP_PUSH_RECORD : OP_RESERVED;
                  send_item(noise_op, rand_byte(), rand_byte(), rand_byte(), rand_byte());
               end
            end else begin
               if (pick < 7) begin
                  send_run(cap, pick == 6);
               end else if (pick < 9) begin
                  send_item(OP_PUSH_RECORD, rand_byte(), rand_byte(), rand_byte(),
                            rand_byte());
               end else begin
                  case ($urandom_range(0, 2))
                     0: noise_op = OP_PUSH_BYTE;
                     1: noise_op = OP_PULL_RECORD;
                     default: noise_op = OP_RESERVED;
                  endcase
                  send_item(noise_op, rand_byte(), rand_byte(), rand_byte(), rand_byte());
               end
            end
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Outgoing with reset settings: empty pull, padding, ignored codes.
      send_item(OP_PULL_RECORD, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_item(OP_PUSH_BYTE, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(OP_PUSH_BYTE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_item(OP_PUSH_BYTE, 8'hA5, 8'h00, 8'h00, 8'h00);
      send_item(OP_PULL_RECORD, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(OP_PULL_RECORD, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(OP_PUSH_RECORD, 8'h00, 8'h05, 8'h11, 8'h22);
      send_item(OP_RESERVED, 8'h00, 8'h05, 8'h11, 8'h22);

      // A zero limit behaves as a limit of one.
      set_config(DIR_OUT, 0);
      send_item(OP_PUSH_BYTE, 8'h5A, 8'h00, 8'h00, 8'h00);
      send_item(OP_PULL_RECORD, 8'h00, 8'h00, 8'h00, 8'h00);

      // Incoming: matching runs, dropped records, empty payload, wrap at limit.
      set_config(DIR_IN, 3);
      send_item(OP_PUSH_RECORD, 8'h00, 8'h05, 8'h11, 8'h22);
      send_item(OP_PUSH_RECORD, 8'h01, 8'h33, 8'h44, 8'hFF);
      send_item(OP_PUSH_RECORD, 8'h02, 8'h66, 8'h77, 8'h88);
      send_item(OP_PUSH_RECORD, 8'h80, 8'h01, 8'h02, 8'h03);
      send_item(OP_PUSH_RECORD, 8'h00, 8'h00, 8'h99, 8'hAA);
      send_item(OP_PUSH_RECORD, 8'h00, 8'h01, 8'hEE, 8'h77);
      send_item(OP_PUSH_RECORD, 8'h00, 8'hFF, 8'h01, 8'h02);
      send_item(OP_PUSH_RECORD, 8'h01, 8'hFF, 8'h00, 8'hFF);
      send_item(OP_PUSH_RECORD, 8'h02, 8'h10, 8'h20, 8'h30);
      send_item(OP_PUSH_BYTE, 8'h01, 8'h00, 8'h00, 8'h00);
      send_item(OP_PULL_RECORD, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(OP_RESERVED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

      // Overfill the byte buffer, then pull with a length that saturates.
      set_config(DIR_OUT, 127);
      repeat (BUFFER_DEPTH + 2) begin
         send_item(OP_PUSH_BYTE, rand_byte(), rand_byte(), rand_byte(), rand_byte());
      end
      repeat (4) begin
         send_item(OP_PULL_RECORD, rand_byte(), rand_byte(), rand_byte(), rand_byte());
      end

      run_phase(DIR_OUT, 85, 6);
      run_phase(DIR_IN, 85, 6);
      run_phase(DIR_OUT, 2, 6);
      run_phase(DIR_IN, 1, 6);
      run_phase(DIR_OUT, $urandom_range(1, 85), 6);
      run_phase(DIR_IN, $urandom_range(1, 85), 6);
      run_phase(DIR_IN, 0, 6);
      run_phase(DIR_OUT, 1, 6);

      drain_block(SETTLE);
      $display("Sent %0d items and checked %0d results over %0d register settings,",
               items_sent, results_checked, settings_used);
      $display("covering both directions, a full byte buffer and broken record runs.");
      if (fail_count == 0) begin
         $display("dns_a_record_data_framer_top_tb passed");
      end else begin
         $display("dns_a_record_data_framer_top_tb failed");
      end
      $finish;
   end

endmodule
